[rtl/core/wsm_pkg.sv]
package wsm_pkg;

	// Field widths of one input item and one result item.
	localparam int ACTION_W  = 2;
	localparam int ADDR_W    = 16;
	localparam int SAMPLE_W  = 8;
	localparam int CHAN_W    = 2;
	localparam int STEP_W    = 16;
	localparam int VOL_W     = 7;
	localparam int LEN_W     = 17;
	localparam int MASK_W    = 4;
	localparam int OUT_W     = 8;
	localparam int MIX_SHIFT = 8;

	// Integer part of an advanced position: one bit more than a byte length.
	localparam int DIV_W = LEN_W + 1;

	// Defaults for the top-level parameters.
	localparam int CHANNELS_DEF  = 4;
	localparam int MEM_BYTES_DEF = 65536;
	localparam int FRAC_BITS_DEF = 12;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE  = 2'd0,
		ACT_START  = 2'd1,
		ACT_VOLUME = 2'd2,
		ACT_MIX    = 2'd3
	} action_t;

	// Per-channel settings stored by a start item.
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [STEP_W-1:0] step;
		logic [LEN_W-1:0]  play_end;
		logic [LEN_W-1:0]  loop_len;
	} chan_cfg_t;

	// Request to the loop wrap remainder unit.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} div_req_t;

	// Answer of the loop wrap remainder unit.
	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] rem;
	} div_rsp_t;

endpackage

[rtl/core/wavetable_sample_mixer_unit.sv]
// Four-channel wavetable mixer over a signed 8-bit sample memory. Each item
// writes a sample byte, starts a channel, sets a channel volume, or asks for
// one mixed sample; only a mix item gives a result. A mix item walks every
// channel; each active channel reads its row from the channel memory and then
// one byte from the sample memory, both registered reads, before it is
// accumulated. A channel that runs past its end with a nonzero loop length
// waits for the bit-serial remainder unit that folds its position back into
// the loop. A finished result waits in the output register while the next
// item is taken; a mix that finishes while the previous result is still
// stalled waits until that result is taken. SAMPLE_MEM_BYTES must be a power
// of two; addresses wrap modulo the memory size. There is no clearing pass:
// sample bytes must be written before a channel plays them.
module wavetable_sample_mixer_unit #(
	parameter int CHANNELS         = wsm_pkg::CHANNELS_DEF,
	parameter int SAMPLE_MEM_BYTES = wsm_pkg::MEM_BYTES_DEF,
	parameter int FRACTION_BITS    = wsm_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [wsm_pkg::ACTION_W-1:0]        action,
	input  logic [wsm_pkg::ADDR_W-1:0]          address,
	input  logic signed [wsm_pkg::SAMPLE_W-1:0] sample_byte,
	input  logic [wsm_pkg::CHAN_W-1:0]          channel,
	input  logic [wsm_pkg::STEP_W-1:0]          increment,
	input  logic [wsm_pkg::VOL_W-1:0]           volume,
	input  logic [wsm_pkg::LEN_W-1:0]           play_end,
	input  logic [wsm_pkg::LEN_W-1:0]           loop_length,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [wsm_pkg::OUT_W-1:0]    mixed_sample,
	output logic [wsm_pkg::MASK_W-1:0]          active_mask
);
	import wsm_pkg::*;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MEM_AW   = $clog2(SAMPLE_MEM_BYTES);
	localparam int POS_W    = LEN_W + FRACTION_BITS;
	localparam int CFG_W    = $bits(chan_cfg_t);
	localparam int ROW_W    = CFG_W + POS_W;
	localparam int PROD_W   = SAMPLE_W + VOL_W + 1;
	localparam int SUM_W    = PROD_W + CH_IDX_W;
	localparam int SHIFT_W  = SUM_W - MIX_SHIFT;
	localparam int WIDE_W   = (MEM_AW > DIV_W) ? MEM_AW : DIV_W;
	localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(2 ** (OUT_W - 1) - 1);
	localparam logic signed [SHIFT_W-1:0] SAT_LO = SHIFT_W'(-(2 ** (OUT_W - 1)));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAN,
		ST_SAMP,
		ST_MAC,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                     state_q;
	logic [CH_IDX_W-1:0]        ch_q;
	logic [CHANNELS-1:0]        active_q;
	logic [VOL_W-1:0]           vol_q [CHANNELS];
	logic signed [SUM_W-1:0]    sum_q;
	chan_cfg_t                  cfg_q;
	logic [POS_W:0]             pos_next_q;
	logic                       result_valid_q;
	logic signed [OUT_W-1:0]    mixed_q;
	logic [MASK_W-1:0]          mask_q;

	action_t                    act;
	logic                       acc;
	logic                       chan_ok;
	logic [CH_IDX_W-1:0]        chan_idx;
	logic                       last_ch;
	logic                       out_free;

	logic                       chan_we;
	logic                       chan_re;
	logic [CH_IDX_W-1:0]        chan_wr_idx;
	logic [ROW_W-1:0]           chan_wr_data;
	logic [ROW_W-1:0]           chan_rd_data;
	chan_cfg_t                  cfg_in;
	chan_cfg_t                  row_cfg;
	logic [POS_W-1:0]           row_pos;
	logic [POS_W:0]             pos_sum;

	logic                       smp_we;
	logic                       smp_re;
	logic [WIDE_W-1:0]          smp_wr_wide;
	logic [WIDE_W-1:0]          smp_rd_wide;
	logic [SAMPLE_W-1:0]        smp_rd_data;
	logic signed [PROD_W-1:0]   prod;

	logic                       wrap;
	logic                       no_loop;
	logic                       need_div;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;
	logic signed [LEN_W+1:0]    base;
	logic [POS_W-1:0]           wrap_pos;
	logic [POS_W-1:0]           wb_pos;

	logic signed [SHIFT_W-1:0]  shifted;
	logic signed [OUT_W-1:0]    sat;

	// Input decode.
	always_comb begin
		act      = action_t'(action);
		acc      = item_valid && !item_stall;
		chan_ok  = int'(channel) < CHANNELS;
		chan_idx = CH_IDX_W'(channel);
		last_ch  = int'(ch_q) == CHANNELS - 1;
		out_free = !result_valid_q || !result_stall;
	end

	assign item_stall = state_q != ST_IDLE;

	// Channel row as it comes out of the channel memory, and its next position.
	always_comb begin
		cfg_in.start    = address;
		cfg_in.step     = increment;
		cfg_in.play_end = play_end;
		cfg_in.loop_len = loop_length;
		row_cfg         = chan_cfg_t'(chan_rd_data[ROW_W-1:POS_W]);
		row_pos         = chan_rd_data[POS_W-1:0];
		pos_sum         = (POS_W + 1)'(row_pos) + (POS_W + 1)'(row_cfg.step);
	end

	// Sample memory addressing wraps modulo its size.
	always_comb begin
		smp_wr_wide = WIDE_W'(address);
		smp_rd_wide = WIDE_W'(row_cfg.start) + WIDE_W'(row_pos[POS_W-1:FRACTION_BITS]);
		smp_we      = acc && (act == ACT_WRITE);
		smp_re      = state_q == ST_SAMP;
	end

	// End test and loop wrap. The fraction bits of end and loop are zero, so
	// only the integer part is compared and reduced.
	always_comb begin
		wrap             = pos_next_q[POS_W:FRACTION_BITS] >= DIV_W'(cfg_q.play_end);
		no_loop          = cfg_q.loop_len == '0;
		need_div         = wrap && !no_loop;
		div_req.start    = (state_q == ST_MAC) && need_div;
		div_req.dividend = pos_next_q[POS_W:FRACTION_BITS] - DIV_W'(cfg_q.play_end);
		div_req.divisor  = cfg_q.loop_len;
		base             = $signed({2'b00, cfg_q.play_end}) - $signed({2'b00, cfg_q.loop_len})
			+ $signed({2'b00, div_rsp.rem});
		if (base < 0) begin
			wrap_pos = '0;
		end else begin
			wrap_pos = {base[LEN_W-1:0], pos_next_q[FRACTION_BITS-1:0]};
		end
		if (state_q == ST_DIV) begin
			wb_pos = wrap_pos;
		end else begin
			wb_pos = pos_next_q[POS_W-1:0];
		end
	end

	// Channel memory port control: start items in idle, position write-back in a mix.
	always_comb begin
		chan_re = (state_q == ST_CHAN) && active_q[ch_q];
		chan_we = (acc && (act == ACT_START) && chan_ok)
			|| ((state_q == ST_MAC) && !need_div)
			|| ((state_q == ST_DIV) && div_rsp.done);
		if (state_q == ST_IDLE) begin
			chan_wr_idx  = chan_idx;
			chan_wr_data = {cfg_in, POS_W'(0)};
		end else begin
			chan_wr_idx  = ch_q;
			chan_wr_data = {cfg_q, wb_pos};
		end
	end

	// Sample times volume, and the output scaling with saturation.
	always_comb begin
		prod    = $signed(smp_rd_data) * $signed({1'b0, vol_q[ch_q]});
		shifted = sum_q[SUM_W-1:MIX_SHIFT];
		if (shifted > SAT_HI) begin
			sat = OUT_W'(SAT_HI);
		end else if (shifted < SAT_LO) begin
			sat = OUT_W'(SAT_LO);
		end else begin
			sat = shifted[OUT_W-1:0];
		end
	end

	// Sequencer: state, channel registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ch_q           <= '0;
			active_q       <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				vol_q[i] <= '0;
			end
			sum_q          <= '0;
			cfg_q          <= '0;
			pos_next_q     <= '0;
			result_valid_q <= 1'b0;
			mixed_q        <= '0;
			mask_q         <= '0;
		end else begin
			// The output state reloads the register itself when it is taken.
			if (result_valid_q && !result_stall && (state_q != ST_OUT)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (act)
							ACT_START: begin
								if (chan_ok) begin
									active_q[chan_idx] <= 1'b1;
								end
							end
							ACT_VOLUME: begin
								if (chan_ok) begin
									vol_q[chan_idx] <= volume;
								end
							end
							ACT_MIX: begin
								ch_q    <= '0;
								sum_q   <= '0;
								state_q <= ST_CHAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHAN: begin
					if (active_q[ch_q]) begin
						state_q <= ST_SAMP;
					end else if (last_ch) begin
						state_q <= ST_OUT;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_SAMP: begin
					cfg_q      <= row_cfg;
					pos_next_q <= pos_sum;
					state_q    <= ST_MAC;
				end
				ST_MAC: begin
					sum_q <= sum_q + SUM_W'(prod);
					if (wrap && no_loop) begin
						active_q[ch_q] <= 1'b0;
					end
					if (need_div) begin
						state_q <= ST_DIV;
					end else if (last_ch) begin
						state_q <= ST_OUT;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_CHAN;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (last_ch) begin
							state_q <= ST_OUT;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_CHAN;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						mixed_q        <= sat;
						mask_q         <= MASK_W'(active_q);
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign mixed_sample = mixed_q;
	assign active_mask  = mask_q;

	wsm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (SAMPLE_MEM_BYTES),
		.IDX_W (MEM_AW)
	) u_sample_ram (
		.clk     (clk),
		.we      (smp_we),
		.wr_idx  (smp_wr_wide[MEM_AW-1:0]),
		.wr_data (sample_byte),
		.re      (smp_re),
		.rd_idx  (smp_rd_wide[MEM_AW-1:0]),
		.rd_data (smp_rd_data)
	);

	wsm_ram #(
		.WIDTH (ROW_W),
		.DEPTH (CHANNELS),
		.IDX_W (CH_IDX_W)
	) u_chan_ram (
		.clk     (clk),
		.we      (chan_we),
		.wr_idx  (chan_wr_idx),
		.wr_data (chan_wr_data),
		.re      (chan_re),
		.rd_idx  (ch_q),
		.rd_data (chan_rd_data)
	);

	wsm_wrap_div u_wrap_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The channel memory is never read and written in the same cycle.
	a_chan_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		chan_we |-> !chan_re)
		else $error("channel memory read and write in the same cycle");

	// The remainder unit only answers while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("wrap remainder done outside of its wait state");

	// Accumulation always comes in the cycle after a sample read.
	a_mac_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> ($past(state_q) == ST_SAMP))
		else $error("accumulate without a preceding sample read");

	// A one-shot channel that reaches its end is stopped.
	a_one_shot_stop: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MAC) && wrap && no_loop) |=> !active_q[$past(ch_q)])
		else $error("one-shot channel still active after its end");

	// A mix item restarts the channel walk from the first channel.
	a_mix_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (act == ACT_MIX)) |=> ((state_q == ST_CHAN) && (ch_q == '0)))
		else $error("mix item did not start at the first channel");

endmodule

[rtl/core/wsm_ram.sv]
module wsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             re,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one read port; read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_idx] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/wsm_wrap_div.sv]
module wsm_wrap_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wsm_pkg::div_req_t req,
	output wsm_pkg::div_rsp_t rsp
);
	import wsm_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [LEN_W-1:0] dsr_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W:0]   trial;
	logic [LEN_W:0]   diff;
	logic [LEN_W-1:0] rem_nxt;

	// Restoring remainder step: bring down one dividend bit, subtract if it fits.
	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		diff  = trial - {1'b0, dsr_q};
		if (trial >= {1'b0, dsr_q}) begin
			rem_nxt = diff[LEN_W-1:0];
		end else begin
			rem_nxt = trial[LEN_W-1:0];
		end
	end

	// One quotient bit per cycle; done pulses once the last bit is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
				dvd_q  <= req.dividend;
				dsr_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
